>>> design/max_planar_chord_subset_macros.svh
// assertion macros for the chord subset block
`ifndef MAX_PLANAR_CHORD_SUBSET_MACROS_SVH
`define MAX_PLANAR_CHORD_SUBSET_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MPCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpcs assertion failed");
// next-cycle implication
`define MPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpcs assertion failed");
`else
`define MPCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/mpcs_pkg.sv
// shared constants and types for the chord subset block
package mpcs_pkg;
  localparam int MAX_POINTS = 64;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_W + 1;
  localparam int TAB_AW     = 2 * PT_W;
  localparam int TAB_DEPTH  = MAX_POINTS * MAX_POINTS;
  localparam int LIST_CAP   = MAX_POINTS / 2;
  localparam int VAL_W      = 6;

  localparam logic [1:0] SKIP_CODE  = 2'd1;
  localparam logic [1:0] SPLIT_CODE = 2'd2;
  localparam logic [1:0] CLOSE_CODE = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_count;
    logic             last_result;
  } res_t;
endpackage

>>> design/mpcs_if.sv
// valid/ready channels for points in and results out
interface mpcs_in_if import mpcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] partner;
  logic             last_point;
  modport source (output valid, output partner, output last_point, input ready);
  modport sink   (input valid, input partner, input last_point, output ready);
endinterface

interface mpcs_out_if import mpcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             is_count;
  logic             last_result;
  modport source (output valid, output value, output is_count, output last_result,
                  input ready);
  modport sink   (input valid, input value, input is_count, input last_result,
                  output ready);
endinterface

>>> design/mpcs_obuf.sv
// output register between the sequencer and the result channel
module mpcs_obuf import mpcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  res_t       data_i,
  output logic       rdy_o,
  mpcs_out_if.source out_ch
);
  logic valid_r;
  res_t data_r;

  // slot frees when empty or draining this cycle
  assign rdy_o = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy_o) begin
      valid_r <= push_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && push_i) begin
      data_r <= data_i;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.value       = data_r.value;
  assign out_ch.is_count    = data_r.is_count;
  assign out_ch.last_result = data_r.last_result;
endmodule

>>> design/max_planar_chord_subset.sv
// max planar chord subset: point load, interval table fill and traceback
// load: one point per cycle; the final point starts the compute
// fill: n(n-1)/2 intervals, each FCELL, FK, FR1 (FR2, FR3 on a split); CRD and CNT give the count
// traceback: chord POP, POPD, SCAN, SCAND, PART (PUSH2 on split); skip SCAN, SCAND
// one run at a time; input ready returns once the final result enters the output register
// reset clears control state only; tables hold no reset value, never read stale
`include "max_planar_chord_subset_macros.svh"
module max_planar_chord_subset import mpcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mpcs_in_if.sink    in_ch,
  mpcs_out_if.source out_ch
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_FCELL = 4'd1;
  localparam logic [3:0] S_FK    = 4'd2;
  localparam logic [3:0] S_FR1   = 4'd3;
  localparam logic [3:0] S_FR2   = 4'd4;
  localparam logic [3:0] S_FR3   = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_CNT   = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_POPD  = 4'd9;
  localparam logic [3:0] S_SCAN  = 4'd10;
  localparam logic [3:0] S_SCAND = 4'd11;
  localparam logic [3:0] S_PART  = 4'd12;
  localparam logic [3:0] S_PUSH2 = 4'd13;
  localparam logic [3:0] S_END   = 4'd14;

  // memories
  logic [VAL_W+1:0]  tab_mem [TAB_DEPTH];
  logic [PT_W-1:0]   ptab_mem [MAX_POINTS];
  logic [2*PT_W-1:0] stk_mem [MAX_POINTS];

  logic              tab_we, tab_re;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;
  logic [VAL_W+1:0]  tab_wdata, tab_rd_r;
  logic              p_we, p_re;
  logic [PT_W-1:0]   p_waddr, p_raddr, p_wdata, p_rd_r;
  logic              s_we, s_re;
  logic [PT_W-1:0]   s_waddr, s_raddr;
  logic [2*PT_W-1:0] s_wdata, s_rd_r;

  // control and working registers
  logic [3:0]      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, n_r, n_nxt, depth_r, depth_nxt;
  logic [PT_W-1:0] i_r, i_nxt, d_r, d_nxt, k_r, k_nxt;
  logic [PT_W-1:0] lo_r, lo_nxt, tj_r, tj_nxt;
  logic [1:0]      case_r, case_nxt;
  logic [VAL_W-1:0] keep_r, keep_nxt, ta_r, ta_nxt;
  logic            rv_r, rv_nxt;
  logic [PT_W-1:0] emitted_r, emitted_nxt;
  logic            pend_v_r, pend_v_nxt;
  res_t            pend_r, pend_nxt;

  logic            ob_push, ob_rdy;
  res_t            ob_data;

  // scratch
  logic [PT_W-1:0]  j, jm1, kk;
  logic [CNT_W-1:0] i7, j7, k7, lo7, tj7, n_load;
  logic [VAL_W-1:0] sc;
  logic [CNT_W-1:0] take7;
  logic             last_cell;

  assign in_ch.ready = (state_r == S_LOAD);

  assign j   = i_r + d_r;
  assign jm1 = j - 1'b1;
  assign i7  = {1'b0, i_r};
  assign j7  = {1'b0, j};
  assign kk  = p_rd_r;
  assign k7  = {1'b0, kk};
  assign lo7 = {1'b0, lo_r};
  assign tj7 = {1'b0, tj_r};
  assign sc  = rv_r ? tab_rd_r[VAL_W-1:0] : '0;
  assign take7 = {1'b0, ta_r} + {1'b0, sc} + 1'b1;
  assign last_cell = (i7 + {1'b0, d_r} + 1'b1) >= n_r;
  assign n_load = (cnt_r < CNT_W'(MAX_POINTS)) ? cnt_r + 1'b1 : cnt_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;   cnt_nxt = cnt_r;   n_nxt = n_r;   depth_nxt = depth_r;
    i_nxt = i_r;   d_nxt = d_r;   k_nxt = k_r;   lo_nxt = lo_r;   tj_nxt = tj_r;
    case_nxt = case_r;   keep_nxt = keep_r;   ta_nxt = ta_r;   rv_nxt = rv_r;
    emitted_nxt = emitted_r;   pend_v_nxt = pend_v_r;   pend_nxt = pend_r;
    tab_we = 1'b0;  tab_waddr = {i_r, j};  tab_wdata = '0;
    tab_re = 1'b0;  tab_raddr = '0;
    p_we = 1'b0;    p_waddr = cnt_r[PT_W-1:0];  p_wdata = in_ch.partner;
    p_re = 1'b0;    p_raddr = j;
    s_we = 1'b0;    s_waddr = depth_r[PT_W-1:0];  s_wdata = '0;
    s_re = 1'b0;    s_raddr = '0;
    ob_push = 1'b0; ob_data = pend_r;
    case (state_r)
      S_LOAD: begin
        // point transfer
        if (in_ch.valid) begin
          if (cnt_r < CNT_W'(MAX_POINTS)) begin
            p_we    = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_ch.last_point) begin
            n_nxt = n_load;
            i_nxt = '0;
            d_nxt = PT_W'(1);
            state_nxt = (n_load >= CNT_W'(2)) ? S_FCELL : S_CRD;
          end
        end
      end
      S_FCELL: begin
        p_re = 1'b1;
        state_nxt = S_FK;
      end
      S_FK: begin
        // classify the chord at the right end and read the first score
        k_nxt = kk;
        tab_re = 1'b1;
        if (kk == i_r) begin
          case_nxt  = CLOSE_CODE;
          tab_raddr = {i_r + 1'b1, jm1};
          rv_nxt    = (i7 + 1'b1) < (j7 - 1'b1);
        end else begin
          case_nxt  = (kk > i_r && kk <= j) ? SPLIT_CODE : SKIP_CODE;
          tab_raddr = {i_r, jm1};
          rv_nxt    = i7 < (j7 - 1'b1);
        end
        state_nxt = S_FR1;
      end
      S_FR1: begin
        if (case_r == SPLIT_CODE) begin
          keep_nxt  = sc;
          tab_re    = 1'b1;
          tab_raddr = {i_r, k_r - 1'b1};
          rv_nxt    = (i7 + 1'b1) < {1'b0, k_r};
          state_nxt = S_FR2;
        end else begin
          tab_we = 1'b1;
          if (case_r == CLOSE_CODE) begin
            tab_wdata = {CLOSE_CODE, sc + 1'b1};
          end else begin
            tab_wdata = {SKIP_CODE, sc};
          end
        end
      end
      S_FR2: begin
        ta_nxt    = sc;
        tab_re    = 1'b1;
        tab_raddr = {k_r + 1'b1, jm1};
        rv_nxt    = ({1'b0, k_r} + CNT_W'(2)) < j7;
        state_nxt = S_FR3;
      end
      S_FR3: begin
        tab_we = 1'b1;
        if ({1'b0, keep_r} <= take7) begin
          tab_wdata = {SPLIT_CODE, take7[VAL_W-1:0]};
        end else begin
          tab_wdata = {SKIP_CODE, keep_r};
        end
      end
      S_CRD: begin
        tab_re    = 1'b1;
        tab_raddr = {PT_W'(0), n_r[PT_W-1:0] - 1'b1};
        rv_nxt    = n_r >= CNT_W'(2);
        state_nxt = S_CNT;
      end
      S_CNT: begin
        // count goes to the pending slot; whole span onto the stack for two or more points
        pend_nxt    = '{value: sc, is_count: 1'b1, last_result: 1'b0};
        pend_v_nxt  = 1'b1;
        emitted_nxt = '0;
        depth_nxt   = '0;
        if (n_r >= CNT_W'(2)) begin
          s_we      = 1'b1;
          s_waddr   = '0;
          s_wdata   = {PT_W'(0), n_r[PT_W-1:0] - 1'b1};
          depth_nxt = CNT_W'(1);
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (depth_r == '0 || {1'b0, emitted_r} == CNT_W'(LIST_CAP)) begin
          state_nxt = S_END;
        end else begin
          s_re      = 1'b1;
          s_raddr   = PT_W'(depth_r - 1'b1);
          depth_nxt = depth_r - 1'b1;
          state_nxt = S_POPD;
        end
      end
      S_POPD: begin
        lo_nxt    = s_rd_r[2*PT_W-1:PT_W];
        tj_nxt    = s_rd_r[PT_W-1:0];
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (tj_r <= lo_r) begin
          state_nxt = S_POP;
        end else begin
          tab_re    = 1'b1;
          tab_raddr = {lo_r, tj_r};
          state_nxt = S_SCAND;
        end
      end
      S_SCAND: begin
        // walk left over skipped endpoints, else emit this one
        if (tab_rd_r[VAL_W+1:VAL_W] == SKIP_CODE) begin
          tj_nxt    = tj_r - 1'b1;
          state_nxt = S_SCAN;
        end else if (ob_rdy || !pend_v_r) begin
          ob_push     = pend_v_r;
          pend_nxt    = '{value: tj_r, is_count: 1'b0, last_result: 1'b0};
          pend_v_nxt  = 1'b1;
          emitted_nxt = emitted_r + 1'b1;
          case_nxt    = tab_rd_r[VAL_W+1:VAL_W];
          p_re        = 1'b1;
          p_raddr     = tj_r;
          state_nxt   = S_PART;
        end
      end
      S_PART: begin
        k_nxt = kk;
        if (case_r == SPLIT_CODE) begin
          if ((k7 + 1'b1) < (tj7 - 1'b1) && depth_r < CNT_W'(MAX_POINTS)) begin
            s_we      = 1'b1;
            s_wdata   = {kk + 1'b1, tj_r - 1'b1};
            depth_nxt = depth_r + 1'b1;
          end
          state_nxt = S_PUSH2;
        end else begin
          if ((lo7 + 1'b1) < (tj7 - 1'b1) && depth_r < CNT_W'(MAX_POINTS)) begin
            s_we      = 1'b1;
            s_wdata   = {lo_r + 1'b1, tj_r - 1'b1};
            depth_nxt = depth_r + 1'b1;
          end
          state_nxt = S_POP;
        end
      end
      S_PUSH2: begin
        if (k_r > lo_r && (lo7 + 1'b1) < {1'b0, k_r} && depth_r < CNT_W'(MAX_POINTS)) begin
          s_we      = 1'b1;
          s_wdata   = {lo_r, k_r - 1'b1};
          depth_nxt = depth_r + 1'b1;
        end
        state_nxt = S_POP;
      end
      S_END: begin
        // flush the pending result as the last of the run
        if (ob_rdy) begin
          ob_push    = 1'b1;
          ob_data    = '{value: pend_r.value, is_count: pend_r.is_count,
                         last_result: 1'b1};
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          depth_nxt  = '0;
          state_nxt  = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // step to the next interval after a table write
    if (tab_we) begin
      if (last_cell) begin
        i_nxt = '0;
        d_nxt = d_r + 1'b1;
        state_nxt = (({1'b0, d_r} + 1'b1) >= n_r) ? S_CRD : S_FCELL;
      end else begin
        i_nxt = i_r + 1'b1;
        state_nxt = S_FCELL;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      depth_r   <= '0;
      emitted_r <= '0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      depth_r   <= depth_nxt;
      emitted_r <= emitted_nxt;
      pend_v_r  <= pend_v_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;    i_r    <= i_nxt;    d_r  <= d_nxt;   k_r <= k_nxt;
    lo_r   <= lo_nxt;   tj_r   <= tj_nxt;   case_r <= case_nxt;
    keep_r <= keep_nxt; ta_r   <= ta_nxt;   rv_r <= rv_nxt;  pend_r <= pend_nxt;
  end

  // score and choice table
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rd_r <= tab_mem[tab_raddr];
    end
  end

  // partner table
  always_ff @(posedge clk) begin
    if (p_we) begin
      ptab_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rd_r <= ptab_mem[p_raddr];
    end
  end

  // traceback stack
  always_ff @(posedge clk) begin
    if (s_we) begin
      stk_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rd_r <= stk_mem[s_raddr];
    end
  end

  mpcs_obuf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (ob_push),
    .data_i (ob_data),
    .rdy_o  (ob_rdy),
    .out_ch (out_ch)
  );

  `MPCS_ASSERT_IMPL(a_tab_we_fill, clk, rst_n, tab_we, (state_r == S_FR1 || state_r == S_FR3))
  `MPCS_ASSERT_IMPL(a_push_room, clk, rst_n, ob_push, ob_rdy)
  `MPCS_ASSERT_IMPL(a_emit_cap, clk, rst_n, 1'b1, ({1'b0, emitted_r} <= CNT_W'(LIST_CAP)))
  `MPCS_ASSERT_NEXT(a_end_load, clk, rst_n, (state_r == S_END && ob_rdy), (state_r == S_LOAD && cnt_r == '0))
endmodule

>>> tb/testbench.sv
// testbench for the max planar chord subset block: predictor, driver, monitor
module testbench import mpcs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0] partner;
    logic       last_point;
  } point_t;

  logic clk;
  logic rst_n;
  mpcs_in_if  in_ch ();
  mpcs_out_if out_ch ();

  max_planar_chord_subset uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  point_t point_queue[$];
  res_t   chord_results[$];
  int     error_count;
  int     total_points;
  int     points_taken;
  bit     stim_ready;
  bit     hold_off;
  bit     hold_done;
  bit     in_fired;

  // predictor copy of the block's tables
  logic [5:0] pred_partner[MAX_POINTS];
  logic [5:0] pred_score[MAX_POINTS][MAX_POINTS];
  logic [1:0] pred_choice[MAX_POINTS][MAX_POINTS];
  int         pred_count;

  function automatic int span_score(int a, int b);
    if (a >= b || b >= MAX_POINTS) return 0;
    return pred_score[a][b];
  endfunction

  // fill tables by span, then trace back chosen chords
  task automatic predict_point(point_t p);
    int n, j, k, s, take, keep, lo, hi, depth, emitted;
    logic [1:0] c;
    int st_lo[MAX_POINTS];
    int st_hi[MAX_POINTS];
    res_t r;
    if (pred_count < MAX_POINTS) begin
      pred_partner[pred_count] = p.partner;
      pred_count++;
    end
    if (!p.last_point) return;
    n = pred_count;
    for (int d = 1; d < n; d++) begin
      for (int i = 0; i + d < n; i++) begin
        j = i + d;
        k = pred_partner[j];
        if (k == i) begin
          s = span_score(i + 1, j - 1) + 1;
          c = CLOSE_CODE;
        end else if (k > i && k <= j) begin
          take = span_score(i, k - 1) + 1 + span_score(k + 1, j - 1);
          keep = span_score(i, j - 1);
          if (keep <= take) begin
            s = take;
            c = SPLIT_CODE;
          end else begin
            s = keep;
            c = SKIP_CODE;
          end
        end else begin
          s = span_score(i, j - 1);
          c = SKIP_CODE;
        end
        pred_score[i][j] = s[5:0];
        pred_choice[i][j] = c;
      end
    end
    r.value = 6'(span_score(0, n - 1));
    r.is_count = 1'b1;
    r.last_result = 1'b0;
    chord_results = {chord_results, r};
    depth = 0;
    emitted = 0;
    if (n - 1 > 0) begin
      st_lo[0] = 0;
      st_hi[0] = n - 1;
      depth = 1;
    end
    while (depth > 0 && emitted < LIST_CAP) begin
      depth--;
      lo = st_lo[depth];
      hi = st_hi[depth];
      while (hi > lo && pred_choice[lo][hi] == SKIP_CODE) hi--;
      if (hi <= lo) continue;
      c = pred_choice[lo][hi];
      r.value = hi[5:0];
      r.is_count = 1'b0;
      r.last_result = 1'b0;
      chord_results = {chord_results, r};
      emitted++;
      if (c == SPLIT_CODE) begin
        k = pred_partner[hi];
        if (k + 1 < hi - 1 && depth < MAX_POINTS) begin
          st_lo[depth] = k + 1; st_hi[depth] = hi - 1; depth++;
        end
        if (k > lo && lo < k - 1 && depth < MAX_POINTS) begin
          st_lo[depth] = lo; st_hi[depth] = k - 1; depth++;
        end
      end else if (lo + 1 < hi - 1 && depth < MAX_POINTS) begin
        st_lo[depth] = lo + 1; st_hi[depth] = hi - 1; depth++;
      end
    end
    chord_results[$].last_result = 1'b1;
    pred_count = 0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // one set of points; well-formed sets pair up shuffled indexes
  task automatic queue_set(int n, bit well_formed);
    int order[];
    int parts[];
    int t, x;
    point_t p;
    order = new[n];
    parts = new[n];
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      x = $urandom_range(i, 0);
      t = order[i]; order[i] = order[x]; order[x] = t;
    end
    for (int i = 0; i < n; i++) parts[i] = $urandom_range(63, 0);
    if (well_formed) begin
      for (int i = 0; i + 1 < n; i += 2) begin
        parts[order[i]] = order[i + 1];
        parts[order[i + 1]] = order[i];
      end
      if (n % 2) parts[order[n - 1]] = order[n - 1];
    end
    for (int i = 0; i < n; i++) begin
      p.partner = 6'(parts[i]);
      p.last_point = (i == n - 1);
      point_queue = {point_queue, p};
    end
  endtask

  task automatic queue_fixed(int unsigned a[$]);
    point_t p;
    foreach (a[i]) begin
      p.partner = 6'(a[i]);
      p.last_point = (i == a.size() - 1);
      point_queue = {point_queue, p};
    end
  endtask

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // stimulus
  initial begin
    int n;
    error_count = 0;
    pred_count = 0;
    points_taken = 0;
    stim_ready = 1'b0;
    // single point, one closing chord, self chord, out of range partners
    queue_fixed('{5});
    queue_fixed('{1, 0});
    queue_fixed('{0, 1, 2});
    queue_fixed('{63, 63, 63, 63});
    queue_fixed('{3, 2, 1, 0});
    queue_fixed('{1, 0, 3, 2, 5, 4});
    queue_fixed('{2, 3, 0, 1});
    // set larger than the point store
    queue_set(70, 1'b1);
    while (point_queue.size() < 380) begin
      if ($urandom_range(19, 0) == 0) n = $urandom_range(64, 33);
      else n = $urandom_range(16, 1);
      queue_set(n, $urandom_range(9, 0) < 7);
    end
    queue_set(64, 1'b1);
    total_points = point_queue.size();
    stim_ready = 1'b1;
    wait (point_queue.size() == 0 && !in_ch.valid);
    wait (chord_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

  function automatic int idle_phase();
    if (total_points == 0) return 0;
    return (points_taken * 4) / total_points;
  endfunction

  // input driver
  always @(negedge clk) begin
    int ph;
    bit idle;
    ph = idle_phase();
    idle = (ph == 1) ? ($urandom_range(99, 0) < 59) :
           (ph == 3) ? ($urandom_range(99, 0) < 34) : 1'b0;
    if (!rst_n || !stim_ready) begin
      in_ch.valid <= 1'b0;
      in_ch.partner <= '0;
      in_ch.last_point <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      // previous transfer done at the last rising edge
      if (!idle && point_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.partner <= point_queue[0].partner;
        in_ch.last_point <= point_queue[0].last_point;
        void'(point_queue.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering points
  always @(posedge clk) begin
    int cnt;
    if (!hold_done && total_points > 0 && points_taken > total_points / 2) begin
      cnt++;
      if (cnt > 3000) begin
        hold_off <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_off <= 1'b1;
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    hold_done = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.partner = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;
  end

  // result ready
  always @(negedge clk) begin
    int ph;
    bit stall;
    ph = idle_phase();
    stall = (ph == 2) ? ($urandom_range(99, 0) < 59) :
            (ph == 3) ? ($urandom_range(99, 0) < 34) : 1'b0;
    out_ch.ready <= rst_n && !hold_off && !stall;
  end

  // monitor: input transfers feed the predictor, result transfers are checked
  always @(posedge clk) begin
    point_t p;
    res_t want;
    in_fired = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        p.partner = in_ch.partner;
        p.last_point = in_ch.last_point;
        predict_point(p);
        points_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (chord_results.size() == 0) begin
          report_mismatch("unexpected result value", out_ch.value, -1);
        end else begin
          want = chord_results.pop_front();
          if (out_ch.value !== want.value)
            report_mismatch("value", out_ch.value, want.value);
          if (out_ch.is_count !== want.is_count)
            report_mismatch("is_count", out_ch.is_count, want.is_count);
          if (out_ch.last_result !== want.last_result)
            report_mismatch("last_result", out_ch.last_result, want.last_result);
        end
      end
    end
  end
endmodule
